### hw/rtl/wtde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtde_pkg
// Shared types, constants and helpers of the word tokeniser.
// ----------------------------------------------------------------------------
package wtde_pkg;

  localparam int CNT_BITS  = 16;  // line and column counter width, 8..32
  localparam int FIELD_CNT = 16;  // counter bits carried in a result word
  localparam int BYTE_W    = 8;

  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [FIELD_CNT-1:0] fcnt_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  typedef enum logic [1:0] {
    KIND_LETTER   = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_TEXT_END = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    byte_t letter;
  } res_t;

  // Everything one input item produces, handed from scanner to result queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    fcnt_t      line;
    fcnt_t      col;
  } scan_res_t;

  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_APOS  = 8'h27;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_UP_A  = 8'h41;
  localparam byte_t CH_UP_Z  = 8'h5A;
  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_LO_A  = 8'h61;
  localparam byte_t CH_LO_Z  = 8'h7A;
  localparam byte_t CASE_OFS = 8'h20;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  // Two letters per digit, first letter in the top byte
  function automatic logic [2*BYTE_W-1:0] digit_pair(input logic [3:0] d);
    logic [2*BYTE_W-1:0] p;
    unique case (d)
      4'd0:    p = "no";
      4'd1:    p = "pa";
      4'd2:    p = "re";
      4'd3:    p = "ci";
      4'd4:    p = "vo";
      4'd5:    p = "mu";
      4'd6:    p = "xa";
      4'd7:    p = "ze";
      4'd8:    p = "bi";
      4'd9:    p = "so";
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/wtde_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtde_if
// Valid/ready channels: input bytes, result words and the config write.
// ----------------------------------------------------------------------------
interface wtde_in_if;
  logic                       valid;
  logic                       ready;
  logic [wtde_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface wtde_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    result_kind;
  logic [wtde_pkg::BYTE_W-1:0]    letter;
  logic [wtde_pkg::FIELD_CNT-1:0] line_number;
  logic [wtde_pkg::FIELD_CNT-1:0] column_number;
  logic                          last_of_run;

  modport source (output valid, result_kind, letter, line_number, column_number,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, letter, line_number, column_number,
                  last_of_run, output ready);
endinterface

interface wtde_cfg_if;
  logic valid;
  logic ready;
  logic interactive_mode;

  modport source (output valid, interactive_mode, input ready);
  modport sink   (input valid, interactive_mode, output ready);
endinterface
`default_nettype wire

### hw/rtl/wtde_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtde_scan
// Scanner state and per-byte decode: classifies the held byte, works out up
// to two result words and the counters after it, commits state on take.
// ----------------------------------------------------------------------------
module wtde_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wtde_pkg::byte_t     in_byte,
  input  wire logic                end_of_input,
  input  wire logic                interactive,
  input  wire logic                take,
  output wtde_pkg::scan_res_t      res
);

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_ESCAPE  = 2'd2,
    MODE_ENDED   = 2'd3
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic               word_open_r, word_open_nxt;
  wtde_pkg::cnt_t     line_r, line_nxt;
  wtde_pkg::cnt_t     col_r, col_nxt;

  logic               emit_wend, emit_tend, emit_l1, emit_l2;
  wtde_pkg::byte_t    let1, let2;
  logic               is_space, is_upper, is_lower, is_digit;
  logic [2*wtde_pkg::BYTE_W-1:0] pair;
  logic [3:0]         digit;

  always_comb begin
    is_space = (in_byte == wtde_pkg::CH_SPACE) ||
               (in_byte >= wtde_pkg::CH_TAB && in_byte <= wtde_pkg::CH_CR);
    is_upper = in_byte >= wtde_pkg::CH_UP_A && in_byte <= wtde_pkg::CH_UP_Z;
    is_lower = (in_byte >= wtde_pkg::CH_LO_A && in_byte <= wtde_pkg::CH_LO_Z) ||
               (in_byte == wtde_pkg::CH_APOS);
    is_digit = in_byte >= wtde_pkg::CH_ZERO && in_byte <= wtde_pkg::CH_NINE;
    digit    = 4'(in_byte - wtde_pkg::CH_ZERO);
    pair     = wtde_pkg::digit_pair(digit);
  end

  always_comb begin
    mode_nxt      = mode_r;
    word_open_nxt = word_open_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    emit_wend     = 1'b0;
    emit_tend     = 1'b0;
    emit_l1       = 1'b0;
    emit_l2       = 1'b0;
    let1          = '0;
    let2          = '0;

    if (mode_r == MODE_ENDED) begin
      // text over: everything ignored until reset
    end else if (end_of_input) begin
      col_nxt       = wtde_pkg::sat_inc(col_r);
      emit_wend     = !interactive && word_open_r;
      emit_tend     = 1'b1;
      word_open_nxt = 1'b0;
      mode_nxt      = MODE_ENDED;
    end else if (mode_r == MODE_COMMENT) begin
      if (in_byte == wtde_pkg::CH_SLASH) begin
        mode_nxt = MODE_NORMAL;
      end
    end else if (mode_r == MODE_ESCAPE && in_byte == wtde_pkg::CH_LF) begin
      // line continuation
      mode_nxt = MODE_NORMAL;
      col_nxt  = '0;
      line_nxt = wtde_pkg::sat_inc(line_r);
    end else begin
      mode_nxt = MODE_NORMAL;
      col_nxt  = wtde_pkg::sat_inc(col_r);
      if (in_byte == wtde_pkg::CH_LF) begin
        col_nxt  = '0;
        line_nxt = wtde_pkg::sat_inc(line_r);
      end
      if (in_byte == wtde_pkg::CH_LF && interactive) begin
        emit_wend     = word_open_r;
        emit_tend     = 1'b1;
        word_open_nxt = 1'b0;
        mode_nxt      = MODE_ENDED;
      end else if (is_space || in_byte == wtde_pkg::CH_DOT) begin
        emit_wend     = word_open_r;
        word_open_nxt = 1'b0;
      end else if (is_upper) begin
        emit_l1       = 1'b1;
        let1          = in_byte + wtde_pkg::CASE_OFS;
        word_open_nxt = 1'b1;
      end else if (is_lower) begin
        emit_l1       = 1'b1;
        let1          = in_byte;
        word_open_nxt = 1'b1;
      end else if (in_byte == wtde_pkg::CH_SLASH) begin
        mode_nxt = MODE_COMMENT;
      end else if (in_byte == wtde_pkg::CH_BSL) begin
        mode_nxt = MODE_ESCAPE;
      end else if (is_digit) begin
        emit_l1       = 1'b1;
        emit_l2       = 1'b1;
        let1          = pair[2*wtde_pkg::BYTE_W-1:wtde_pkg::BYTE_W];
        let2          = pair[wtde_pkg::BYTE_W-1:0];
        word_open_nxt = 1'b1;
      end
    end
  end

  // Pack the emitted words in order: word end before text end
  always_comb begin
    res.n    = 2'd0;
    res.r0   = '{kind: wtde_pkg::KIND_LETTER, letter: '0};
    res.r1   = '{kind: wtde_pkg::KIND_LETTER, letter: '0};
    res.line = wtde_pkg::fcnt_t'(line_nxt);
    res.col  = wtde_pkg::fcnt_t'(col_nxt);
    priority if (emit_tend && emit_wend) begin
      res.n  = 2'd2;
      res.r0 = '{kind: wtde_pkg::KIND_WORD_END, letter: '0};
      res.r1 = '{kind: wtde_pkg::KIND_TEXT_END, letter: '0};
    end else if (emit_tend) begin
      res.n  = 2'd1;
      res.r0 = '{kind: wtde_pkg::KIND_TEXT_END, letter: '0};
    end else if (emit_wend) begin
      res.n  = 2'd1;
      res.r0 = '{kind: wtde_pkg::KIND_WORD_END, letter: '0};
    end else if (emit_l2) begin
      res.n  = 2'd2;
      res.r0 = '{kind: wtde_pkg::KIND_LETTER, letter: let1};
      res.r1 = '{kind: wtde_pkg::KIND_LETTER, letter: let2};
    end else if (emit_l1) begin
      res.n  = 2'd1;
      res.r0 = '{kind: wtde_pkg::KIND_LETTER, letter: let1};
    end else begin
      res.n  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      word_open_r <= 1'b0;
      line_r      <= wtde_pkg::cnt_t'(1);
      col_r       <= '0;
    end else if (take) begin
      mode_r      <= mode_nxt;
      word_open_r <= word_open_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wtde_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtde_outq
// Two-entry result register. Loads all words of one item at once, hands them
// out one per cycle while out_ch.ready is high; the head drives out_ch.
// ----------------------------------------------------------------------------
module wtde_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire wtde_pkg::scan_res_t res,
  output logic                     room,
  wtde_out_if.source               out_ch
);

  logic [1:0]          cnt_r, cnt_nxt;
  wtde_pkg::res_t      e0_r, e0_nxt;
  wtde_pkg::res_t      e1_r, e1_nxt;
  wtde_pkg::fcnt_t     line_r, line_nxt;
  wtde_pkg::fcnt_t     col_r, col_nxt;
  logic                pop;

  assign pop  = (cnt_r != 2'd0) && out_ch.ready;
  // a new item may land when empty or once the last word left is leaving
  assign room = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);

  always_comb begin
    cnt_nxt  = cnt_r;
    e0_nxt   = e0_r;
    e1_nxt   = e1_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    priority if (load) begin
      cnt_nxt  = res.n;
      e0_nxt   = res.r0;
      e1_nxt   = res.r1;
      line_nxt = res.line;
      col_nxt  = res.col;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      e0_nxt  = e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r   <= e0_nxt;
    e1_r   <= e1_nxt;
    line_r <= line_nxt;
    col_r  <= col_nxt;
  end

  assign out_ch.valid         = cnt_r != 2'd0;
  assign out_ch.result_kind   = e0_r.kind;
  assign out_ch.letter        = e0_r.letter;
  assign out_ch.line_number   = line_r;
  assign out_ch.column_number = col_r;
  assign out_ch.last_of_run   = cnt_r == 2'd1;

endmodule
`default_nettype wire

### hw/rtl/word_tokenizer_with_digit_expansion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// word_tokenizer_with_digit_expansion
// Byte stream to word letters, word ends and end of text, with line/column.
// ----------------------------------------------------------------------------
// A byte is taken into an input register, decoded combinationally and its one
// or two result words written together into a two-entry result register, which
// hands them out one per cycle while out_ch.ready is high. A new byte is
// accepted every cycle as long as results drain; a digit, or a word end followed
// by end of text, fills both entries of the result register, so throughput is
// one result word per cycle, i.e. one byte per cycle for plain text, while a
// digit gives two result words. Bytes giving no result (comments, dropped
// characters) pass at one per cycle even while results are held. The
// interactive_mode register may be written at any time the block is idle;
// cfg_ch.ready is always high.
// ----------------------------------------------------------------------------
module word_tokenizer_with_digit_expansion (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wtde_in_if.sink     in_ch,
  wtde_out_if.source  out_ch,
  wtde_cfg_if.sink    cfg_ch
);

  logic                interactive_r;
  logic                inv_r;
  wtde_pkg::byte_t     byte_r;
  logic                eoi_r;
  logic                take;
  logic                room;
  wtde_pkg::scan_res_t res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interactive_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      interactive_r <= cfg_ch.interactive_mode;
    end
  end

  // items without results need no space in the result register
  assign take        = inv_r && ((res.n == 2'd0) || room);
  assign in_ch.ready = !inv_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ch.ready) begin
      inv_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.in_byte;
      eoi_r  <= in_ch.end_of_input;
    end
  end

  wtde_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte      (byte_r),
    .end_of_input (eoi_r),
    .interactive  (interactive_r),
    .take         (take),
    .res          (res)
  );

  wtde_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take && (res.n != 2'd0)),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### hw/rtl/wtde_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtde_chk
// Port-level checks on the result channel of the tokeniser.
// ----------------------------------------------------------------------------
module wtde_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    out_kind,
  input wire logic [wtde_pkg::BYTE_W-1:0]    out_letter,
  input wire logic [wtde_pkg::FIELD_CNT-1:0] out_line,
  input wire logic [wtde_pkg::FIELD_CNT-1:0] out_col,
  input wire logic                          out_last
);

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_letter) && $stable(out_line) && $stable(out_col) &&
      $stable(out_last))
    else $error("result word changed while stalled");

  a_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wtde_pkg::KIND_LETTER |-> out_letter == '0)
    else $error("letter not zero on a word or text end");

  a_text_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wtde_pkg::KIND_TEXT_END |-> out_last)
    else $error("end of text is not the last word of its run");

  // the second word of a run is already held when the first leaves
  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("run broken after a non-final word");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line != '0)
    else $error("line number zero");

endmodule

bind word_tokenizer_with_digit_expansion wtde_chk u_wtde_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.result_kind),
  .out_letter (out_ch.letter),
  .out_line   (out_ch.line_number),
  .out_col    (out_ch.column_number),
  .out_last   (out_ch.last_of_run)
);
`default_nettype wire

### test/word_tokenizer_with_digit_expansion_tb.sv
// ----------------------------------------------------------------------------
// word_tokenizer_with_digit_expansion_tb
// Drives bytes through the tokeniser and checks every result word against a
// predictor that tracks scan mode, pending word and the line/column counts.
// ----------------------------------------------------------------------------
module word_tokenizer_with_digit_expansion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 480;
  localparam int TAIL_RUN    = 20;
  localparam string DIGIT_SYLLABLES = "noparecivomuxazebiso";

  typedef enum logic [1:0] {
    SCAN_NORMAL, SCAN_COMMENT, SCAN_ESCAPE, SCAN_ENDED
  } scan_t;

  typedef enum int {
    END_BY_FLAG, END_BY_FLAG_INTERACTIVE, END_BY_NEWLINE
  } ending_t;

  typedef struct {
    wtde_pkg::kind_t kind;
    wtde_pkg::byte_t letter;
    wtde_pkg::fcnt_t line;
    wtde_pkg::fcnt_t col;
    logic            last;
  } token_t;

  class token_predictor;
    bit             interactive;
    scan_t          mode;
    bit             word_open;
    wtde_pkg::cnt_t line;
    wtde_pkg::cnt_t col;
    token_t         pending[$];
    int             errors;

    function new();
      interactive = 1'b0;
      mode        = SCAN_NORMAL;
      word_open   = 1'b0;
      line        = wtde_pkg::cnt_t'(1);
      col         = '0;
      errors      = 0;
    endfunction

    function wtde_pkg::cnt_t step_count(wtde_pkg::cnt_t v);
      return (v == '1) ? v : v + wtde_pkg::cnt_t'(1);
    endfunction

    function void push(wtde_pkg::kind_t k, wtde_pkg::byte_t l);
      token_t t;
      t.kind   = k;
      t.letter = l;
      t.line   = wtde_pkg::fcnt_t'(line);
      t.col    = wtde_pkg::fcnt_t'(col);
      t.last   = 1'b0;
      pending.push_back(t);
    endfunction

    function void end_word();
      if (word_open) push(wtde_pkg::KIND_WORD_END, '0);
      word_open = 1'b0;
    endfunction

    function void scan_plain(wtde_pkg::byte_t c);
      int d;
      col = step_count(col);
      if (c == wtde_pkg::CH_LF) begin
        col  = '0;
        line = step_count(line);
        if (interactive) begin
          end_word();
          mode = SCAN_ENDED;
          push(wtde_pkg::KIND_TEXT_END, '0);
          return;
        end
      end
      if (c == wtde_pkg::CH_SPACE || c == wtde_pkg::CH_DOT ||
          (c >= wtde_pkg::CH_TAB && c <= wtde_pkg::CH_CR)) begin
        end_word();
      end else if (c >= wtde_pkg::CH_UP_A && c <= wtde_pkg::CH_UP_Z) begin
        push(wtde_pkg::KIND_LETTER, wtde_pkg::byte_t'(c + wtde_pkg::CASE_OFS));
        word_open = 1'b1;
      end else if ((c >= wtde_pkg::CH_LO_A && c <= wtde_pkg::CH_LO_Z) ||
                   c == wtde_pkg::CH_APOS) begin
        push(wtde_pkg::KIND_LETTER, c);
        word_open = 1'b1;
      end else if (c == wtde_pkg::CH_SLASH) begin
        mode = SCAN_COMMENT;
      end else if (c == wtde_pkg::CH_BSL) begin
        mode = SCAN_ESCAPE;
      end else if (c >= wtde_pkg::CH_ZERO && c <= wtde_pkg::CH_NINE) begin
        d = int'(c - wtde_pkg::CH_ZERO);
        push(wtde_pkg::KIND_LETTER, wtde_pkg::byte_t'(DIGIT_SYLLABLES[2*d]));
        push(wtde_pkg::KIND_LETTER, wtde_pkg::byte_t'(DIGIT_SYLLABLES[2*d+1]));
        word_open = 1'b1;
      end
    endfunction

    // Called once per accepted input word
    function void take_word(wtde_pkg::byte_t c, bit eoi);
      int n0;
      n0 = pending.size();
      if (mode == SCAN_ENDED) return;
      if (eoi) begin
        col = step_count(col);
        if (!interactive) end_word();
        word_open = 1'b0;
        mode = SCAN_ENDED;
        push(wtde_pkg::KIND_TEXT_END, '0);
      end else if (mode == SCAN_COMMENT) begin
        if (c == wtde_pkg::CH_SLASH) mode = SCAN_NORMAL;
      end else if (mode == SCAN_ESCAPE) begin
        mode = SCAN_NORMAL;
        if (c == wtde_pkg::CH_LF) begin
          col  = '0;
          line = step_count(line);
        end else begin
          scan_plain(c);
        end
      end else begin
        scan_plain(c);
      end
      if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_word(logic [1:0] kind, wtde_pkg::byte_t letter,
                             wtde_pkg::fcnt_t ln, wtde_pkg::fcnt_t cl, logic last);
      token_t t;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: kind %0d letter %0h", kind, letter);
        errors++;
        return;
      end
      t = pending.pop_front();
      if (t.kind !== kind) begin
        $error("result_kind: expected %0d, got %0d", t.kind, kind);
        errors++;
      end
      if (t.letter !== letter) begin
        $error("letter: expected %0h, got %0h", t.letter, letter);
        errors++;
      end
      if (t.line !== ln) begin
        $error("line_number: expected %0d, got %0d", t.line, ln);
        errors++;
      end
      if (t.col !== cl) begin
        $error("column_number: expected %0d, got %0d", t.col, cl);
        errors++;
      end
      if (t.last !== last) begin
        $error("last_of_run: expected %0b, got %0b", t.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on;
  int   quiet_cycles;
  token_predictor sb = new();

  wtde_in_if  in_ch();
  wtde_out_if out_ch();
  wtde_cfg_if cfg_ch();

  word_tokenizer_with_digit_expansion i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.result_kind, out_ch.letter, out_ch.line_number,
                      out_ch.column_number, out_ch.last_of_run);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("word_tokenizer_with_digit_expansion_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side back-pressure
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // valid is left high after a word so back-to-back words need no re-raise
  task automatic send_word(input wtde_pkg::byte_t b, input bit eoi);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_word(b, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(wtde_pkg::byte_t'(s[i]), 1'b0);
  endtask

  // Only while idle; bytes with no result may still be in flight, hence the pause
  task automatic write_mode(input bit m);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.interactive_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.interactive = m;
  endtask

  function automatic wtde_pkg::byte_t random_text_byte();
    int unsigned r;
    wtde_pkg::byte_t c;
    r = $urandom_range(0, 99);
    if (r < 40)      c = wtde_pkg::CH_LO_A + wtde_pkg::byte_t'($urandom_range(0, 25));
    else if (r < 50) c = wtde_pkg::CH_UP_A + wtde_pkg::byte_t'($urandom_range(0, 25));
    else if (r < 55) c = wtde_pkg::CH_APOS;
    else if (r < 65) c = wtde_pkg::CH_ZERO + wtde_pkg::byte_t'($urandom_range(0, 9));
    else if (r < 75) c = wtde_pkg::CH_SPACE;
    else if (r < 80) c = wtde_pkg::CH_TAB + wtde_pkg::byte_t'($urandom_range(0, 4));
    else if (r < 85) c = wtde_pkg::CH_DOT;
    else if (r < 89) c = wtde_pkg::CH_SLASH;
    else if (r < 93) c = wtde_pkg::CH_BSL;
    else             c = wtde_pkg::byte_t'($urandom_range(0, 255));
    if (sb.mode == SCAN_ESCAPE && $urandom_range(0, 2) == 0) c = wtde_pkg::CH_LF;
    // a bare newline would end the text for good in interactive mode
    if (sb.interactive && sb.mode == SCAN_NORMAL && c == wtde_pkg::CH_LF)
      c = wtde_pkg::CH_SPACE;
    return c;
  endfunction

  initial begin
    ending_t ending;
    rst_n                   <= 1'b0;
    idle_on                  = 1'b0;
    quiet_cycles            <= 0;
    in_ch.valid             <= 1'b0;
    in_ch.in_byte           <= '0;
    in_ch.end_of_input      <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.interactive_mode <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: interactive, comment across a newline, continuation
    write_mode(1'b1);
    send_text("Az'9/\nx/\\\n0\\.");
    write_mode(1'b0);
    send_text("Za \tb\n5");
    send_word(wtde_pkg::CH_CR, 1'b0);
    send_word(8'h0B, 1'b0);
    send_word(8'h0C, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_text("1.");

    for (int p = 0; p < 4; p++) begin
      write_mode(p % 2 == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_word(random_text_byte(), 1'b0);
      end
    end

    // runs of dropped bytes and newlines, no idling from here on
    idle_on = 1'b0;
    while (sb.mode != SCAN_NORMAL)
      send_word((sb.mode == SCAN_COMMENT) ? wtde_pkg::CH_SLASH : wtde_pkg::CH_SPACE,
                1'b0);
    for (int i = 0; i < TAIL_RUN; i++)
      send_word(wtde_pkg::byte_t'($urandom_range(128, 255)), 1'b0);
    send_word("k", 1'b0);
    for (int i = 0; i < TAIL_RUN; i++) send_word(wtde_pkg::CH_LF, 1'b0);
    send_word("e", 1'b0);

    ending = ending_t'($urandom_range(0, 2));
    if (ending != END_BY_FLAG) write_mode(1'b1);
    if ($urandom_range(0, 1) == 1)
      send_word(wtde_pkg::CH_LO_A + wtde_pkg::byte_t'($urandom_range(0, 25)), 1'b0);
    if (ending == END_BY_NEWLINE) send_word(wtde_pkg::CH_LF, 1'b0);
    else send_word(wtde_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
    // text has ended: these must give nothing
    for (int i = 0; i < 20; i++)
      send_word(wtde_pkg::byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("word_tokenizer_with_digit_expansion_tb: done, clean");
    end else begin
      $display("word_tokenizer_with_digit_expansion_tb: done, errors");
    end
    $finish;
  end

endmodule
